// File: hdl/sac_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the set-associative true-lru cache model
// no dependencies

package sac_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 32;

    // request field and counter widths
    localparam int MODE_W  = 2;
    localparam int TOTAL_W = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_SB_W   = 3;
    localparam int CFG_OFF_W  = 5;
    localparam int CFG_WAYS_W = 4;

    localparam logic [CFG_SB_W-1:0]   SET_BITS_RST = 3'd1;
    localparam logic [CFG_OFF_W-1:0]  OFFSET_RST   = 5'd4;
    localparam logic [CFG_WAYS_W-1:0] WAYS_RST     = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS = 2'd0,
        CFG_OFFSET   = 2'd1,
        CFG_WAYS     = 2'd2
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_FETCH  = 2'd3
    } mode_t;

    // result of checking one way against the lookup tag
    typedef struct packed {
        logic match;   // valid and tag equal
        logic empty;   // way not valid
        logic lru;     // valid and rank zero
    } way_status_t;

endpackage

// File: hdl/set_assoc_cache_lru_sim_top.sv
`timescale 1ns / 1ps
// top level of the set-associative true-lru cache model
// depends on sac_pkg, sac_row_mem and sac_way_cmp

// Each request is one memory access (load, store, modify or instruction
// fetch) to a byte address. The address is split into block offset, set index
// and tag from the configuration registers; the set's row is read from the
// line store and then a single way check unit walks the ways, one per cycle,
// looking for a hit, the first empty way and the least recently used way.
// A final step writes the updated row back (tags, valid bits, true-lru ranks)
// and posts the result with the running hit, miss and eviction totals.
// Each access runs a set read, a check of each way in use by the check unit
// and a row write-back before its result is registered;
// a modify runs two accesses back to back, load then store, and gives two
// results, the second marked last. An instruction fetch is accepted and
// gives nothing. The block takes a new request only when it is
// idle, but a finished result may still sit in the output register while
// the next request is accepted; the write-back of an access waits there
// while the output register holds a result not yet taken. Configuration
// writes are taken at any cycle and should only be made while idle; line
// state and totals survive them. No clearing pass is needed after reset.

module set_assoc_cache_lru_sim_top #(
    parameter int MAX_SET_BITS = sac_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = sac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH   = sac_pkg::ADDR_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sac_pkg::MODE_W-1:0]       mode,
    input  logic [ADDR_WIDTH-1:0]            address,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic                             miss,
    output logic                             eviction,
    output logic                             last,
    output logic [sac_pkg::TOTAL_W-1:0]      hits_total,
    output logic [sac_pkg::TOTAL_W-1:0]      misses_total,
    output logic [sac_pkg::TOTAL_W-1:0]      evictions_total,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SET_W  = MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int WCNT_W = $clog2(MAX_WAYS + 1);
    localparam int SB_W   = $clog2(MAX_SET_BITS + 1);
    localparam int SH_W   = ((SB_W > sac_pkg::CFG_OFF_W) ? SB_W : sac_pkg::CFG_OFF_W) + 1;
    localparam int TAG_W  = ADDR_WIDTH;
    localparam int CNT_W  = sac_pkg::TOTAL_W;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [sac_pkg::CFG_SB_W-1:0]   set_bits_reg;
    logic [sac_pkg::CFG_OFF_W-1:0]  offset_reg;
    logic [sac_pkg::CFG_WAYS_W-1:0] ways_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= sac_pkg::SET_BITS_RST;
            offset_reg   <= sac_pkg::OFFSET_RST;
            ways_reg     <= sac_pkg::WAYS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sac_pkg::CFG_SET_BITS: set_bits_reg <= cfg_data[sac_pkg::CFG_SB_W-1:0];
                sac_pkg::CFG_OFFSET:   offset_reg   <= cfg_data[sac_pkg::CFG_OFF_W-1:0];
                sac_pkg::CFG_WAYS:     ways_reg     <= cfg_data[sac_pkg::CFG_WAYS_W-1:0];
                default:               ;  // unmapped index, write dropped
            endcase
        end
    end

    // clamp set bits and associativity to what the store holds
    logic [SB_W-1:0]   eff_sb;
    logic [WCNT_W-1:0] eff_ways;

    assign eff_sb = (int'(set_bits_reg) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                        : SB_W'(set_bits_reg);

    always_comb
    begin
        if (ways_reg == '0)
            eff_ways = WCNT_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            eff_ways = WCNT_W'(MAX_WAYS);
        else
            eff_ways = WCNT_W'(ways_reg);
    end

    // ------------------------------------------------------------------
    // address split, done on the request as it is accepted
    // ------------------------------------------------------------------
    logic [SH_W-1:0]       tag_shift;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W:0]        set_mask;
    logic [SET_W-1:0]      in_set;
    logic [TAG_W-1:0]      in_tag;

    assign tag_shift = SH_W'(offset_reg) + SH_W'(eff_sb);
    assign addr_sh   = address >> offset_reg;
    assign set_mask  = ((SET_W + 1)'(1) << eff_sb) - (SET_W + 1)'(1);
    assign in_set    = SET_W'(addr_sh) & set_mask[SET_W-1:0];
    assign in_tag    = address >> tag_shift;

    // ------------------------------------------------------------------
    // sequencer and access registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic              modify_reg, modify_next;
    logic              first_reg, first_next;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [WAY_W-1:0]  wc_reg, wc_next;

    // scan results
    logic              hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]  hit_way_reg, hit_way_next;
    logic              empty_found_reg, empty_found_next;
    logic [WAY_W-1:0]  empty_way_reg, empty_way_next;
    logic              lru_found_reg, lru_found_next;
    logic [WAY_W-1:0]  lru_way_reg, lru_way_next;

    // totals
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]  miss_cnt_reg, miss_cnt_next;
    logic [CNT_W-1:0]  evict_cnt_reg, evict_cnt_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic              out_evict_reg, out_evict_next;
    logic              out_last_reg, out_last_next;

    // line store row
    logic [MAX_WAYS-1:0]             row_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] row_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tag;
    logic [MAX_WAYS-1:0]             new_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] new_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;

    logic                 rd_en;
    logic                 wr_en;
    logic                 commit;
    logic [WAY_W-1:0]     victim;
    logic                 do_evict;
    logic [RANK_W-1:0]    old_rank;
    sac_pkg::way_status_t way_st;

    sac_row_mem #(
        .SET_W  (SET_W),
        .WAYS   (MAX_WAYS),
        .RANK_W (RANK_W),
        .TAG_W  (TAG_W)
    ) u_row_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_set   (set_reg),
        .wr_en    (wr_en),
        .wr_set   (set_reg),
        .wr_valid (new_valid),
        .wr_rank  (new_rank),
        .wr_tag   (new_tag),
        .rd_valid (row_valid),
        .rd_rank  (row_rank),
        .rd_tag   (row_tag)
    );

    // the one way check unit, stepped over the ways of the set
    sac_way_cmp #(
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W)
    ) u_way_cmp (
        .line_valid (row_valid[wc_reg]),
        .line_tag   (row_tag[wc_reg]),
        .line_rank  (row_rank[wc_reg]),
        .lookup_tag (tag_reg),
        .status     (way_st)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_en    = (state_reg == ST_READ);
    // write-back only when the result register is free or being emptied
    assign commit   = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
    assign wr_en    = commit;

    // hit way, else the way to fill or replace on a miss; with no rank-0 way the fallback is way 0
    always_comb
    begin
        do_evict = !hit_found_reg && !empty_found_reg;
        if (hit_found_reg)
            victim = hit_way_reg;
        else if (empty_found_reg)
            victim = empty_way_reg;
        else if (lru_found_reg)
            victim = lru_way_reg;
        else
            victim = '0;
        // a filled empty way starts at rank zero
        old_rank = (!hit_found_reg && empty_found_reg) ? '0 : row_rank[victim];
    end

    // true-lru rank update of the row, all ways side by side
    always_comb
    begin
        logic sel;
        logic in_use;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            sel    = (WAY_W'(i) == victim);
            in_use = (i < int'(eff_ways));
            new_valid[i] = row_valid[i] | (sel && !hit_found_reg);
            new_tag[i]   = (sel && !hit_found_reg) ? tag_reg : row_tag[i];
            if (sel)
                new_rank[i] = RANK_W'(eff_ways - WCNT_W'(1));
            else if (in_use && row_valid[i] && (row_rank[i] > old_rank))
                new_rank[i] = row_rank[i] - RANK_W'(1);
            else
                new_rank[i] = row_rank[i];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        modify_next      = modify_reg;
        first_next       = first_reg;
        set_next         = set_reg;
        tag_next         = tag_reg;
        wc_next          = wc_reg;
        hit_found_next   = hit_found_reg;
        hit_way_next     = hit_way_reg;
        empty_found_next = empty_found_reg;
        empty_way_next   = empty_way_reg;
        lru_found_next   = lru_found_reg;
        lru_way_next     = lru_way_reg;
        hit_cnt_next     = hit_cnt_reg;
        miss_cnt_next    = miss_cnt_reg;
        evict_cnt_next   = evict_cnt_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_hit_next     = out_hit_reg;
        out_evict_next   = out_evict_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // instruction fetches are taken and dropped
                if (in_valid && (mode != sac_pkg::MODE_FETCH))
                begin
                    modify_next = (mode == sac_pkg::MODE_MODIFY);
                    first_next  = 1'b1;
                    set_next    = in_set;
                    tag_next    = in_tag;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                wc_next          = '0;
                hit_found_next   = 1'b0;
                empty_found_next = 1'b0;
                lru_found_next   = 1'b0;
                state_next       = ST_SCAN;
            end
            ST_SCAN:
            begin
                // keep the first way that meets each condition
                if (way_st.match && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_way_next   = wc_reg;
                end
                if (way_st.empty && !empty_found_reg)
                begin
                    empty_found_next = 1'b1;
                    empty_way_next   = wc_reg;
                end
                if (way_st.lru && !lru_found_reg)
                begin
                    lru_found_next = 1'b1;
                    lru_way_next   = wc_reg;
                end
                if (WCNT_W'(wc_reg) == eff_ways - WCNT_W'(1))
                    state_next = ST_UPDATE;
                else
                    wc_next = wc_reg + WAY_W'(1);
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    if (hit_found_reg)
                        hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    else
                        miss_cnt_next = miss_cnt_reg + CNT_W'(1);
                    if (do_evict)
                        evict_cnt_next = evict_cnt_reg + CNT_W'(1);
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_found_reg;
                    out_evict_next = do_evict;
                    out_last_next  = !(modify_reg && first_reg);
                    // modify: the store half goes back to the same set
                    if (modify_reg && first_reg)
                    begin
                        first_next = 1'b0;
                        state_next = ST_READ;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        modify_reg      <= modify_next;
        first_reg       <= first_next;
        set_reg         <= set_next;
        tag_reg         <= tag_next;
        wc_reg          <= wc_next;
        hit_found_reg   <= hit_found_next;
        hit_way_reg     <= hit_way_next;
        empty_found_reg <= empty_found_next;
        empty_way_reg   <= empty_way_next;
        lru_found_reg   <= lru_found_next;
        lru_way_reg     <= lru_way_next;
        out_hit_reg     <= out_hit_next;
        out_evict_reg   <= out_evict_next;
        out_last_reg    <= out_last_next;
    end

    // result ports; totals change only when a new result is loaded
    assign out_valid       = out_valid_reg;
    assign hit             = out_hit_reg;
    assign miss            = !out_hit_reg;
    assign eviction        = out_evict_reg;
    assign last            = out_last_reg;
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;
    assign evictions_total = evict_cnt_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result posted outside write-back");

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_evict_reg |-> !out_hit_reg)
        else $error("eviction reported on a hit");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (WCNT_W'(wc_reg) < eff_ways))
        else $error("way counter beyond ways in use");

    a_totals_step: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_cnt_reg != $past(hit_cnt_reg)) || (miss_cnt_reg != $past(miss_cnt_reg))
        |-> $past(commit))
        else $error("totals moved without a write-back");

    a_modify_second: assert property (@(posedge clk) disable iff (!rst_n)
        commit && modify_reg && first_reg |=> (state_reg == ST_READ) && !first_reg)
        else $error("modify store half not started");

endmodule

// File: hdl/sac_way_cmp.sv
`timescale 1ns / 1ps
// shared way check unit: one way of a set per cycle against the lookup tag
// depends on sac_pkg

module sac_way_cmp #(
    parameter int TAG_W  = 32,
    parameter int RANK_W = 3
) (
    input  logic              line_valid,
    input  logic [TAG_W-1:0]  line_tag,
    input  logic [RANK_W-1:0] line_rank,
    input  logic [TAG_W-1:0]  lookup_tag,
    output sac_pkg::way_status_t status
);

    always_comb
    begin
        status.match = line_valid && (line_tag == lookup_tag);
        status.empty = !line_valid;
        status.lru   = line_valid && (line_rank == '0);
    end

endmodule

// File: hdl/sac_row_mem.sv
`timescale 1ns / 1ps
// line store: one row per set holding valid bits, ranks and tags of all ways
// rows never written read as invalid with rank zero; depends on nothing

module sac_row_mem #(
    parameter int SET_W  = 6,
    parameter int WAYS   = 8,
    parameter int RANK_W = 3,
    parameter int TAG_W  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [SET_W-1:0]             rd_set,
    input  logic                         wr_en,
    input  logic [SET_W-1:0]             wr_set,
    input  logic [WAYS-1:0]              wr_valid,
    input  logic [WAYS-1:0][RANK_W-1:0]  wr_rank,
    input  logic [WAYS-1:0][TAG_W-1:0]   wr_tag,
    output logic [WAYS-1:0]              rd_valid,
    output logic [WAYS-1:0][RANK_W-1:0]  rd_rank,
    output logic [WAYS-1:0][TAG_W-1:0]   rd_tag
);

    localparam int DEPTH = 1 << SET_W;

    logic [WAYS-1:0]             valid_mem [DEPTH];
    logic [WAYS-1:0][RANK_W-1:0] rank_mem  [DEPTH];
    logic [WAYS-1:0][TAG_W-1:0]  tag_mem   [DEPTH];

    logic [DEPTH-1:0]            written_reg;
    logic                        rd_written_reg;
    logic [WAYS-1:0]             rd_valid_reg;
    logic [WAYS-1:0][RANK_W-1:0] rd_rank_reg;
    logic [WAYS-1:0][TAG_W-1:0]  rd_tag_reg;

    // row written marks, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                written_reg[wr_set] <= 1'b1;
            if (rd_en)
                rd_written_reg <= written_reg[rd_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_set] <= wr_valid;
            rank_mem[wr_set]  <= wr_rank;
            tag_mem[wr_set]   <= wr_tag;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_set];
            rd_rank_reg  <= rank_mem[rd_set];
            rd_tag_reg   <= tag_mem[rd_set];
        end
    end

    assign rd_valid = rd_written_reg ? rd_valid_reg : '0;
    assign rd_rank  = rd_written_reg ? rd_rank_reg : '0;
    assign rd_tag   = rd_tag_reg;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the set-associative true-lru cache model
// depends on sac_pkg and set_assoc_cache_lru_sim_top

module testbench;

    import sac_pkg::*;

    localparam int SETS_LOG_MAX = MAX_SET_BITS_DEF;
    localparam int WAYS_MAX     = MAX_WAYS_DEF;
    localparam int LINES        = (1 << SETS_LOG_MAX) * WAYS_MAX;
    // worst case: a modify runs two accesses back to back, plus margin
    localparam int SETTLE_CYCLES = 2 * (WAYS_MAX + 3) + 16;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int PRINT_LIMIT   = 40;

    // one result of one access: flags and running totals
    typedef struct {
        logic        hit;
        logic        miss;
        logic        eviction;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } cache_outcome_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode = MODE_LOAD;
    logic [31:0]           address = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  hit;
    logic                  miss;
    logic                  eviction;
    logic                  last;
    logic [TOTAL_W-1:0]    hits_total;
    logic [TOTAL_W-1:0]    misses_total;
    logic [TOTAL_W-1:0]    evictions_total;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    set_assoc_cache_lru_sim_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .miss            (miss),
        .eviction        (eviction),
        .last            (last),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow of the tag store, the rank table, the totals and the registers
    // ------------------------------------------------------------------
    logic                 line_ok   [LINES];
    logic [63:0]          line_tagv [LINES];
    logic [2:0]           line_age  [LINES];
    logic [31:0]          hit_cnt;
    logic [31:0]          miss_cnt;
    logic [31:0]          evict_cnt;
    logic [CFG_SB_W-1:0]   set_bits_reg;
    logic [CFG_OFF_W-1:0]  offset_reg;
    logic [CFG_WAYS_W-1:0] ways_reg;

    // accesses predicted at acceptance, oldest first
    cache_outcome_t pending_outcomes[$];

    int errors = 0;
    int cycles = 0;

    // sender burst bookkeeping
    int burst_left = 0;
    bit req_up     = 1'b0;

    // receiver stall pattern
    int stall_left  = 0;
    int stall_style = 0;
    int style_left  = 0;

    initial begin
        for (int i = 0; i < LINES; i++) begin
            line_ok[i]   = 1'b0;
            line_tagv[i] = '0;
            line_age[i]  = '0;
        end
        hit_cnt      = '0;
        miss_cnt     = '0;
        evict_cnt    = '0;
        set_bits_reg = SET_BITS_RST;
        offset_reg   = OFFSET_RST;
        ways_reg     = WAYS_RST;
    end

    function automatic int eff_set_bits();
        return (set_bits_reg > SETS_LOG_MAX) ? SETS_LOG_MAX : int'(set_bits_reg);
    endfunction

    function automatic int eff_ways();
        if (ways_reg == 0)
            return 1;
        return (ways_reg > WAYS_MAX) ? WAYS_MAX : int'(ways_reg);
    endfunction

    // one lookup: hit, fill of the first empty way, or eviction of the
    // rank-0 way; the touched way then becomes the most recent
    function automatic void lru_lookup_update(logic [31:0] addr, logic is_last);
        int             sb;
        int             ways;
        int             base;
        int             w;
        logic [63:0]    wide;
        logic [63:0]    set_no;
        logic [63:0]    tg;
        logic [2:0]     old_age;
        cache_outcome_t r;
        sb     = eff_set_bits();
        ways   = eff_ways();
        wide   = {32'd0, addr};
        set_no = (wide >> offset_reg) & ((64'd1 << sb) - 64'd1);
        tg     = wide >> (int'(offset_reg) + sb);
        base   = int'(set_no) * WAYS_MAX;
        r.eviction = 1'b0;

        w = 0;
        while (w < ways && !(line_ok[base + w] && line_tagv[base + w] == tg))
            w++;
        if (w < ways) begin
            r.hit   = 1'b1;
            r.miss  = 1'b0;
            hit_cnt = hit_cnt + 1;
        end else begin
            r.hit    = 1'b0;
            r.miss   = 1'b1;
            miss_cnt = miss_cnt + 1;
            w = 0;
            while (w < ways && line_ok[base + w])
                w++;
            if (w < ways) begin
                line_age[base + w] = '0;
            end else begin
                r.eviction = 1'b1;
                evict_cnt  = evict_cnt + 1;
                w = 0;
                while (w < ways && !(line_ok[base + w] && line_age[base + w] == 0))
                    w++;
                // stale ranks after a ways change: fall back to way 0
                if (w == ways)
                    w = 0;
            end
            line_ok[base + w]   = 1'b1;
            line_tagv[base + w] = tg;
        end

        old_age = line_age[base + w];
        for (int i = 0; i < ways; i++)
            if (line_ok[base + i] && line_age[base + i] > old_age)
                line_age[base + i] = line_age[base + i] - 3'd1;
        line_age[base + w] = 3'(ways - 1);

        r.last      = is_last;
        r.hits      = hit_cnt;
        r.misses    = miss_cnt;
        r.evictions = evict_cnt;
        pending_outcomes.push_back(r);
    endfunction

    function automatic void predict_request(mode_t m, logic [31:0] addr);
        case (m)
            MODE_FETCH: ;
            MODE_MODIFY: begin
                lru_lookup_update(addr, 1'b0);
                lru_lookup_update(addr, 1'b1);
            end
            default: lru_lookup_update(addr, 1'b1);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("tb: mismatch at cycle %0d: %s got %0h expected %0h",
                     cycles, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // result side: check accepted results, then pick the next ready value
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cache_outcome_t w;
        logic           next_ready;
        if (rst_n && out_valid && out_ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected result", 32'({hit, miss, eviction, last}), '0);
            end else begin
                w = pending_outcomes.pop_front();
                if (hit !== w.hit)
                    report_mismatch("hit", 32'(hit), 32'(w.hit));
                if (miss !== w.miss)
                    report_mismatch("miss", 32'(miss), 32'(w.miss));
                if (eviction !== w.eviction)
                    report_mismatch("eviction", 32'(eviction), 32'(w.eviction));
                if (last !== w.last)
                    report_mismatch("last", 32'(last), 32'(w.last));
                if (hits_total !== w.hits)
                    report_mismatch("hits_total", hits_total, w.hits);
                if (misses_total !== w.misses)
                    report_mismatch("misses_total", misses_total, w.misses);
                if (evictions_total !== w.evictions)
                    report_mismatch("evictions_total", evictions_total, w.evictions);
            end
        end

        // stall style changes every so often: none, short, long, alternating
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(40, 160);
        end else begin
            style_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else begin
            next_ready = 1'b1;
            case (stall_style)
                1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 2);
                2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 12);
                3: stall_left = 1;
                default: ;
            endcase
        end
        out_ready <= next_ready;
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // offer one request and hold it until accepted; bursts with gaps
    task automatic send_request(mode_t m, logic [31:0] addr);
        if (burst_left == 0) begin
            if (req_up)
                in_valid <= 1'b0;
            req_up = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            // now and then a long stretch with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        mode     <= m;
        address  <= addr;
        req_up   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_request(m, addr);
        burst_left--;
    endtask

    // drop valid, wait for every expected result and let the block settle
    task automatic wait_idle();
        if (req_up)
            in_valid <= 1'b0;
        req_up     = 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers on consecutive edges while the block is idle;
    // raw data may carry bits above a register's width, which are dropped
    task automatic set_config(logic [CFG_DATA_W-1:0] sb_data,
                              logic [CFG_DATA_W-1:0] off_data,
                              logic [CFG_DATA_W-1:0] ways_data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_data  <= sb_data;
        @(posedge clk);
        set_bits_reg = sb_data[CFG_SB_W-1:0];
        cfg_index <= CFG_OFFSET;
        cfg_data  <= off_data;
        @(posedge clk);
        offset_reg = off_data[CFG_OFF_W-1:0];
        cfg_index <= CFG_WAYS;
        cfg_data  <= ways_data;
        @(posedge clk);
        ways_reg = ways_data[CFG_WAYS_W-1:0];
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: two sets, one way, 16-byte blocks
    task automatic test_reset_settings();
        send_request(MODE_LOAD, 32'h0000_0000);     // cold fill
        send_request(MODE_LOAD, 32'h0000_000C);     // same block, hit
        send_request(MODE_STORE, 32'h0000_0040);    // same set, other tag: evict
        send_request(MODE_FETCH, 32'h0000_0000);    // ignored, no result
        send_request(MODE_MODIFY, 32'hFFFF_FFFF);   // miss then hit
        send_request(MODE_LOAD, 32'h0000_0010);     // set 1 evict
    endtask

    // register extremes and out-of-range values
    task automatic test_config_extremes();
        // set bits above the maximum, an offset of 16, ways above the maximum
        set_config(5'd7, 5'd16, 5'd15);
        send_request(MODE_LOAD, 32'hFFFF_FFFF);
        send_request(MODE_STORE, 32'h0000_0000);
        send_request(MODE_MODIFY, 32'h8000_0000);
        send_request(MODE_LOAD, 32'h7FFF_FFFF);
        // zero set bits gives one set, zero ways acts as one way
        set_config(5'd0, 5'd2, 5'd0);
        send_request(MODE_LOAD, 32'h0000_0003);
        send_request(MODE_LOAD, 32'h0000_0000);
        send_request(MODE_STORE, 32'h0000_0004);
    endtask

    // shrink the ways so that no rank-0 line is left among those in use
    task automatic test_stale_ranks();
        set_config(5'd1, 5'd4, 5'd4);
        send_request(MODE_LOAD, 32'h0000_0000);
        send_request(MODE_LOAD, 32'h0000_0020);
        send_request(MODE_LOAD, 32'h0000_0040);
        send_request(MODE_LOAD, 32'h0000_0060);
        send_request(MODE_LOAD, 32'h0000_0000);     // way 0 most recent
        send_request(MODE_LOAD, 32'h0000_0020);     // way 1 most recent
        set_config(5'd1, 5'd4, 5'd2);
        send_request(MODE_STORE, 32'h0000_0080);    // no rank 0: victim is way 0
        send_request(MODE_LOAD, 32'h0000_0020);
        set_config(5'd1, 5'd4, 5'd8);
        send_request(MODE_LOAD, 32'h0000_0040);     // kept line in way 2
    endtask

    // phases of random traffic over a hot address pool, each phase with
    // its own register settings; line state carries across phases
    task automatic test_random_traffic();
        logic [31:0] hot_pool[$];
        logic [31:0] addr;
        logic [31:0] block_mask;
        logic [31:0] base_addr;
        int          sb;
        int          off;
        int          ways;
        int          sb_eff;
        int          accesses;
        int          pick;
        mode_t       m;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin sb = 1; off = 1;  ways = 1; end
                1: begin sb = 6; off = 16; ways = 8; end
                2: begin sb = 3; off = 5;  ways = 4; end
                default: begin
                    sb   = $urandom_range(0, 7);
                    off  = $urandom_range(1, 16);
                    ways = $urandom_range(0, 15);
                end
            endcase
            sb_eff = (sb > SETS_LOG_MAX) ? SETS_LOG_MAX : sb;
            // keep the tag within the width of the tag store
            if (off + sb_eff < 2)
                off = 2;
            set_config({2'($urandom_range(0, 3)), 3'(sb)}, 5'(off),
                       {1'($urandom_range(0, 1)), 4'(ways)});

            // hot pool: some random blocks, some tags sharing one set
            hot_pool.delete();
            base_addr = $urandom();
            for (int k = 0; k < $urandom_range(4, 24); k++) begin
                if (k % 2 == 0)
                    hot_pool.push_back($urandom());
                else
                    hot_pool.push_back(base_addr ^ (32'(k) << (off + sb_eff)));
            end
            block_mask = (32'd1 << off) - 32'd1;

            accesses = 0;
            while (accesses < 110) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    m = MODE_LOAD;
                else if (pick < 65)
                    m = MODE_STORE;
                else if (pick < 85)
                    m = MODE_MODIFY;
                else
                    m = MODE_FETCH;
                if ($urandom_range(0, 99) < 12)
                    addr = $urandom();
                else
                    addr = hot_pool[$urandom_range(0, hot_pool.size() - 1)]
                           ^ ($urandom() & block_mask);
                send_request(m, addr);
                accesses++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_config_extremes();
        test_stale_ranks();
        test_random_traffic();

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
